[src/x86ild_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the x86 instruction length decoder.
// Holds opcode constants, parser phase codes and the opcode classifier; no dependencies.
package x86ild_pkg;

    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 6;
    localparam int MINL_W  = 6;
    localparam int SKIP_W  = 4;
    localparam int IMM_W   = 3;
    localparam int MOD_W   = 2;
    localparam int PHASE_W = 3;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPCODE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MODRM  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SIB    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd4;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    // Opcode ranges and single opcodes
    localparam logic [BYTE_W-1:0] OP_ONE_LO   = 8'h40;
    localparam logic [BYTE_W-1:0] OP_ONE_HI   = 8'h5F;
    localparam logic [BYTE_W-1:0] OP_NOP      = 8'h90;
    localparam logic [BYTE_W-1:0] OP_RET      = 8'hC3;
    localparam logic [BYTE_W-1:0] OP_MOV_LO   = 8'h88;
    localparam logic [BYTE_W-1:0] OP_MOV_HI   = 8'h8B;
    localparam logic [BYTE_W-1:0] OP_GRP1_I32 = 8'h81;
    localparam logic [BYTE_W-1:0] OP_GRP1_I8  = 8'h83;
    localparam logic [BYTE_W-1:0] OP_CALL     = 8'hE8;
    localparam logic [BYTE_W-1:0] OP_JMP      = 8'hE9;

    // ModR/M fields
    localparam logic [MOD_W-1:0] MOD_IND   = 2'd0;
    localparam logic [MOD_W-1:0] MOD_DISP8 = 2'd1;
    localparam logic [MOD_W-1:0] MOD_DISP32 = 2'd2;
    localparam logic [MOD_W-1:0] MOD_REG   = 2'd3;
    localparam logic [2:0]       RM_SIB    = 3'd4;
    localparam logic [2:0]       RM_DISP32 = 3'd5;

    typedef enum logic [2:0] {
        OPC_ONE_BYTE,
        OPC_MODRM,
        OPC_MODRM_I32,
        OPC_MODRM_I8,
        OPC_REL32,
        OPC_UNKNOWN
    } op_class_t;

    function automatic op_class_t classify_opcode(input logic [BYTE_W-1:0] b);
        op_class_t c;
        if ((b >= OP_ONE_LO && b <= OP_ONE_HI) || b == OP_NOP || b == OP_RET)
            c = OPC_ONE_BYTE;
        else if (b >= OP_MOV_LO && b <= OP_MOV_HI)
            c = OPC_MODRM;
        else if (b == OP_GRP1_I32)
            c = OPC_MODRM_I32;
        else if (b == OP_GRP1_I8)
            c = OPC_MODRM_I8;
        else if (b == OP_CALL || b == OP_JMP)
            c = OPC_REL32;
        else
            c = OPC_UNKNOWN;
        return c;
    endfunction

    // Displacement bytes implied by a mod field
    function automatic logic [SKIP_W-1:0] disp_for_mod(input logic [MOD_W-1:0] m);
        logic [SKIP_W-1:0] d;
        if (m == MOD_DISP8)
            d = 4'd1;
        else if (m == MOD_DISP32)
            d = 4'd4;
        else
            d = 4'd0;
        return d;
    endfunction

    // Clamp the configured minimum into 1..32
    function automatic logic [TOTAL_W-1:0] effective_min(input logic [MINL_W-1:0] m);
        logic [TOTAL_W-1:0] e;
        if (m == '0)
            e = 6'd1;
        else if (m > 6'd32)
            e = 6'd32;
        else
            e = m;
        return e;
    endfunction

endpackage

[src/x86_instruction_length_decoder.sv]
`timescale 1ns / 1ps
// Top level of the byte-serial x86 instruction length decoder.
// Depends on x86ild_pkg for opcode classes, phase codes and helper functions.
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ---------------------------
//  in       sink       in_valid  / in_stall     code_byte, start_req
//  out      source     out_valid / out_stall    status, total_length
//  cfg      sink       cfg_valid / cfg_ready    min_length
//
// One byte per cycle sustained while the output is not stalled. A beat lands in
// the input register; once the output register is free, the parser logic
// updates phase and counters and loads at most one result into the output
// register. in_stall rises only while the output register holds an untaken
// result and the input register holds a beat waiting for it. Reset clears all
// control state and sets the minimum length to 5.
module x86_instruction_length_decoder
    import x86ild_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   code_byte,
    input  logic                start_req,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic [TOTAL_W-1:0]  total_length,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MINL_W-1:0]   min_length
);

    // Input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                start_reg;

    // Parser state
    logic [PHASE_W-1:0]  phase_reg,     phase_next;
    logic [TOTAL_W-1:0]  total_reg,     total_next;
    logic [SKIP_W-1:0]   skip_reg,      skip_next;
    logic [IMM_W-1:0]    imm_reg,       imm_next;
    logic [MOD_W-1:0]    mod_reg,       mod_next;
    logic [MINL_W-1:0]   min_len_reg;

    // Output register
    logic                out_valid_reg;
    logic                status_reg,    status_next;
    logic [TOTAL_W-1:0]  length_reg,    length_next;
    logic                emit_next;

    logic                out_free;
    logic                advance;
    logic                in_take;

    // The output register can load when empty or when its beat is taken now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    // Hold the input beat while the parser cannot advance.
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign total_length = length_reg;

    // Parser: one byte through phase, counters and result decision.
    always_comb
    begin
        logic [PHASE_W-1:0]  ph;
        logic [TOTAL_W-1:0]  tot;
        logic [SKIP_W-1:0]   skp;
        logic [IMM_W-1:0]    imm;
        logic [MOD_W-1:0]    md;
        logic [TOTAL_W-1:0]  emin;
        logic                operand_done;
        logic                boundary;
        logic [SKIP_W-1:0]   extra;
        logic [SKIP_W-1:0]   skp_sum;
        op_class_t           cls;

        ph   = phase_reg;
        tot  = total_reg;
        skp  = skip_reg;
        imm  = imm_reg;
        md   = mod_reg;
        emin = effective_min(min_len_reg);
        operand_done = 1'b0;
        boundary     = 1'b0;
        extra        = '0;
        skp_sum      = '0;
        cls          = classify_opcode(byte_reg);

        status_next = STATUS_OK;
        length_next = '0;
        emit_next   = 1'b0;

        // A start drops any partial instruction and restarts the count.
        if (start_reg)
        begin
            ph  = PH_OPCODE;
            tot = '0;
            skp = '0;
            imm = '0;
            md  = '0;
        end

        if (ph != PH_IDLE)
        begin
            tot = tot + 6'd1;
            unique case (ph)
                PH_OPCODE:
                begin
                    imm = '0;
                    unique case (cls)
                        OPC_ONE_BYTE:  boundary = 1'b1;
                        OPC_MODRM:     ph = PH_MODRM;
                        OPC_MODRM_I32:
                        begin
                            imm = 3'd4;
                            ph  = PH_MODRM;
                        end
                        OPC_MODRM_I8:
                        begin
                            imm = 3'd1;
                            ph  = PH_MODRM;
                        end
                        OPC_REL32:
                        begin
                            skp = 4'd4;
                            ph  = PH_SKIP;
                        end
                        default:
                        begin
                            // Unknown opcode: report and go quiet until next start.
                            status_next = STATUS_UNKNOWN;
                            length_next = '0;
                            emit_next   = 1'b1;
                            ph          = PH_IDLE;
                        end
                    endcase
                end
                PH_MODRM:
                begin
                    md = byte_reg[7:6];
                    priority if (md == MOD_REG)
                    begin
                        operand_done = 1'b1;
                        extra        = '0;
                    end
                    else if (byte_reg[2:0] == RM_SIB)
                        ph = PH_SIB;
                    else if (md == MOD_IND && byte_reg[2:0] == RM_DISP32)
                    begin
                        operand_done = 1'b1;
                        extra        = 4'd4;
                    end
                    else
                    begin
                        operand_done = 1'b1;
                        extra        = disp_for_mod(md);
                    end
                end
                PH_SIB:
                begin
                    operand_done = 1'b1;
                    if (mod_reg == MOD_IND && byte_reg[2:0] == RM_DISP32)
                        extra = 4'd4;
                    else
                        extra = disp_for_mod(mod_reg);
                end
                PH_SKIP:
                begin
                    if (skp != '0)
                        skp = skp - 4'd1;
                    if (skp == '0)
                        boundary = 1'b1;
                end
                default:
                    ph = PH_IDLE;
            endcase

            // Displacement plus any pending immediate still to pass over.
            if (operand_done)
            begin
                skp_sum = extra + {1'b0, imm};
                skp     = skp_sum;
                if (skp_sum == '0)
                    boundary = 1'b1;
                else
                    ph = PH_SKIP;
            end

            // Instruction complete: stop once the minimum is covered.
            if (boundary)
            begin
                if (tot >= emin)
                begin
                    status_next = STATUS_OK;
                    length_next = tot;
                    emit_next   = 1'b1;
                    ph          = PH_IDLE;
                end
                else
                    ph = PH_OPCODE;
            end
        end

        phase_next = ph;
        total_next = tot;
        skip_next  = skp;
        imm_next   = imm;
        mod_next   = md;
    end

    // Input register: load on an accepted beat, drop once parsed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= code_byte;
            start_reg <= start_req;
        end
    end

    // Parser state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            total_reg   <= '0;
            skip_reg    <= '0;
            imm_reg     <= '0;
            mod_reg     <= '0;
            min_len_reg <= 6'd5;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                total_reg <= total_next;
                skip_reg  <= skip_next;
                imm_reg   <= imm_next;
                mod_reg   <= mod_next;
            end
            if (cfg_valid && cfg_ready)
                min_len_reg <= min_length;
        end
    end

    // Output register: advance on a new result, drop a taken beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit_next)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_next)
        begin
            status_reg <= status_next;
            length_reg <= length_next;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for x86_instruction_length_decoder: random code streams,
// output stalls and a range of minimum lengths.
// Depends on x86ild_pkg (widths, phase, status and opcode constants) and the decoder RTL.

import x86ild_pkg::*;

class length_scoreboard;
    typedef struct packed {
        logic               status;
        logic [TOTAL_W-1:0] total;
    } verdict_t;

    verdict_t           awaited[$];
    logic [MINL_W-1:0]  min_len;
    logic [PHASE_W-1:0] phase;
    logic [TOTAL_W-1:0] covered;
    logic [SKIP_W-1:0]  skip_left;
    logic [IMM_W-1:0]   imm_bytes;
    logic [MOD_W-1:0]   last_mod;
    int                 errors;

    function new();
        min_len   = 6'd5;
        phase     = PH_IDLE;
        covered   = '0;
        skip_left = '0;
        imm_bytes = '0;
        last_mod  = '0;
        errors    = 0;
    endfunction

    function void queue_verdict(logic st, logic [TOTAL_W-1:0] len);
        verdict_t v;
        v.status = st;
        v.total  = len;
        awaited.push_back(v);
    endfunction

    // Instruction boundary: stop once the clamped minimum is covered.
    function void close_insn();
        logic [TOTAL_W-1:0] floor_len;
        if (min_len == '0)
            floor_len = 6'd1;
        else if (min_len > 6'd32)
            floor_len = 6'd32;
        else
            floor_len = min_len;
        if (covered >= floor_len)
        begin
            queue_verdict(STATUS_OK, covered);
            phase = PH_IDLE;
        end
        else
            phase = PH_OPCODE;
    endfunction

    function logic [SKIP_W-1:0] mod_disp(logic [MOD_W-1:0] m);
        if (m == MOD_DISP8)
            return 4'd1;
        if (m == MOD_DISP32)
            return 4'd4;
        return 4'd0;
    endfunction

    // Addressing bytes done; skip displacement plus immediate.
    function void operand_done(logic [SKIP_W-1:0] disp);
        skip_left = disp + SKIP_W'(imm_bytes);
        if (skip_left == '0)
            close_insn();
        else
            phase = PH_SKIP;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic start);
        if (start)
        begin
            phase     = PH_OPCODE;
            covered   = '0;
            skip_left = '0;
            imm_bytes = '0;
            last_mod  = '0;
        end
        if (phase == PH_IDLE)
            return;
        covered = covered + 1'b1;
        case (phase)
            PH_OPCODE:
            begin
                imm_bytes = '0;
                if ((b >= OP_ONE_LO && b <= OP_ONE_HI) || b == OP_NOP || b == OP_RET)
                    close_insn();
                else if (b >= OP_MOV_LO && b <= OP_MOV_HI)
                    phase = PH_MODRM;
                else if (b == OP_GRP1_I32)
                begin
                    imm_bytes = 3'd4;
                    phase     = PH_MODRM;
                end
                else if (b == OP_GRP1_I8)
                begin
                    imm_bytes = 3'd1;
                    phase     = PH_MODRM;
                end
                else if (b == OP_CALL || b == OP_JMP)
                begin
                    skip_left = 4'd4;
                    phase     = PH_SKIP;
                end
                else
                begin
                    queue_verdict(STATUS_UNKNOWN, '0);
                    phase = PH_IDLE;
                end
            end
            PH_MODRM:
            begin
                last_mod = b[7:6];
                if (b[7:6] == MOD_REG)
                    operand_done('0);
                else if (b[2:0] == RM_SIB)
                    phase = PH_SIB;
                else if (b[7:6] == MOD_IND && b[2:0] == RM_DISP32)
                    operand_done(4'd4);
                else
                    operand_done(mod_disp(b[7:6]));
            end
            PH_SIB:
            begin
                // base field of 5 with mod 0 means a bare disp32
                if (last_mod == MOD_IND && b[2:0] == RM_DISP32)
                    operand_done(4'd4);
                else
                    operand_done(mod_disp(last_mod));
            end
            PH_SKIP:
            begin
                if (skip_left != '0)
                    skip_left = skip_left - 1'b1;
                if (skip_left == '0)
                    close_insn();
            end
            default:
                phase = PH_IDLE;
        endcase
    endfunction

    function void check_result(logic st, logic [TOTAL_W-1:0] len);
        verdict_t want;
        if (awaited.size() == 0)
        begin
            $error("unexpected result: status %0d total_length %0d", st, len);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (st !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
        end
        if (len !== want.total)
        begin
            $error("total_length: expected %0d, actual %0d", want.total, len);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WARMUP_LEN     = 24;
    localparam int WARMUP_SPLIT   = 18;
    localparam int PHASE_COUNT    = 14;
    localparam int BYTES_PER_PHASE = 70;

    // Directed beats: bit 8 is start_req, bits 7:0 the code byte.
    // The first 18 run at the reset minimum of 5, the rest at minimum 0.
    localparam logic [8:0] WARMUP [WARMUP_LEN] = '{
        {1'b0, 8'hFF},                                  // before any start: dropped
        {1'b1, OP_NOP}, {1'b0, OP_ONE_LO}, {1'b0, OP_ONE_HI}, {1'b0, OP_RET},
        {1'b0, OP_MOV_HI}, {1'b0, 8'hC0},               // register ModR/M ends at 6
        {1'b0, 8'h00},                                  // after a result: dropped
        {1'b1, OP_JMP}, {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03}, {1'b0, 8'h04},
        {1'b1, OP_GRP1_I8}, {1'b0, 8'h45}, {1'b0, 8'h7F}, {1'b0, 8'h80},
        {1'b0, 8'hAA},                                  // unknown opcode mid-region
        {1'b1, OP_MOV_LO + 8'd1}, {1'b0, 8'h44}, {1'b0, 8'h05}, {1'b0, 8'h11},
        {1'b1, OP_MOV_LO}, {1'b1, OP_ONE_LO + 8'h0F}   // restart mid-instruction
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  code_byte    = '0;
    logic               start_req    = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               status;
    logic [TOTAL_W-1:0] total_length;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [MINL_W-1:0]  min_length   = '0;

    length_scoreboard   sb;
    logic [BYTE_W-1:0]  plan[$];
    bit                 no_gaps      = 1'b0;
    int                 hold_cnt     = 0;
    int                 stuck_cycles = 0;
    int                 sent_bytes   = 0;

    x86_instruction_length_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_byte    (code_byte),
        .start_req    (start_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .total_length (total_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .min_length   (min_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Output backpressure: start a stall burst at random, hold it for its
    // length, and keep it off entirely during gap-free phases.
    always @(posedge clk)
    begin
        if (hold_cnt == 0 && !no_gaps && $urandom_range(0, 99) < 20)
            hold_cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(5, 30);
        if (hold_cnt != 0 && !no_gaps)
        begin
            out_stall <= 1'b1;
            hold_cnt--;
        end
        else
            out_stall <= 1'b0;
    end

    // Sample every channel at the edge: check results before noting the
    // new input beat, track config writes, and run the stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(status, total_length);
            if (in_valid && !in_stall)
                sb.note_byte(code_byte, start_req);
            if (cfg_valid && cfg_ready)
                sb.min_len = min_length;
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("x86_instruction_length_decoder: mismatch");
                    $finish;
                end
            end
        end
    end

    // Offer one beat after an optional gap and hold it until taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= b;
        start_req <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_min(input logic [MINL_W-1:0] v);
        cfg_valid  <= 1'b1;
        min_length <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait out every expected result, then let the pipeline
    // flush any beat that produces nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Append one well-formed instruction with random operand content.
    task automatic build_insn();
        int               kind;
        int               pick;
        int               disp;
        int               imm;
        logic [BYTE_W-1:0] op;
        logic [MOD_W-1:0] md;
        logic [2:0]       reg_f;
        logic [2:0]       rm;
        logic [BYTE_W-1:0] sib;
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            pick = $urandom_range(0, 33);
            if (pick < 32)
                plan.push_back(OP_ONE_LO + 8'(pick));
            else
                plan.push_back(pick == 32 ? OP_NOP : OP_RET);
        end
        else if (kind == 3)
        begin
            plan.push_back($urandom_range(0, 1) ? OP_CALL : OP_JMP);
            repeat (4) plan.push_back(8'($urandom));
        end
        else
        begin
            pick = $urandom_range(0, 5);
            if (pick < 4)
                op = OP_MOV_LO + 8'(pick);
            else
                op = (pick == 4) ? OP_GRP1_I32 : OP_GRP1_I8;
            imm   = (op == OP_GRP1_I32) ? 4 : ((op == OP_GRP1_I8) ? 1 : 0);
            reg_f = 3'($urandom);
            rm    = ($urandom_range(0, 3) == 0) ? RM_SIB : 3'($urandom);
            sib   = 8'($urandom);
            disp  = 0;
            case ($urandom_range(0, 4))
                0: md = MOD_REG;
                1:
                begin
                    md = MOD_IND;
                    if (rm == RM_DISP32)
                        disp = 4;
                end
                2:
                begin
                    md   = MOD_DISP8;
                    disp = 1;
                end
                default:
                begin
                    md   = MOD_DISP32;
                    disp = 4;
                end
            endcase
            // SIB base 5 under mod 0 pulls in a disp32
            if (md == MOD_IND && rm == RM_SIB)
                disp = (sib[2:0] == RM_DISP32) ? 4 : 0;
            plan.push_back(op);
            plan.push_back({md, reg_f, rm});
            if (md != MOD_REG && rm == RM_SIB)
                plan.push_back(sib);
            repeat (disp + imm) plan.push_back(8'($urandom));
        end
    endtask

    // One region: mostly instruction streams that reach the minimum, some
    // cut short (next start lands mid-instruction), some with trailing
    // bytes the block drops, and some plain noise.
    task automatic send_region(input int reach);
        int mode;
        int cut;
        plan.delete();
        mode = $urandom_range(0, 19);
        if (mode == 0)
            repeat ($urandom_range(1, 8)) plan.push_back(8'($urandom));
        else
        begin
            do
                build_insn();
            while (plan.size() < reach);
            if (mode == 1)
            begin
                cut = $urandom_range(1, plan.size());
                while (plan.size() > cut)
                    void'(plan.pop_back());
            end
            else if (mode == 2)
                repeat ($urandom_range(1, 4)) plan.push_back(8'($urandom));
        end
        foreach (plan[i])
            send_byte(plan[i], i == 0);
        sent_bytes += plan.size();
    endtask

    initial
    begin
        logic [MINL_W-1:0] floor_set;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: extremes, every opcode class but OP_GRP1_I32, ignored beats,
        // an unknown opcode and a restart in mid-instruction.
        for (int i = 0; i < WARMUP_SPLIT; i++)
            send_byte(WARMUP[i][7:0], WARMUP[i][8]);
        settle();
        write_min(6'd0);
        for (int i = WARMUP_SPLIT; i < WARMUP_LEN; i++)
            send_byte(WARMUP[i][7:0], WARMUP[i][8]);

        // Random phases, each under its own minimum; every fourth runs with
        // no gaps and no stalls.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle();
            no_gaps = (ph % 4 == 3);
            case (ph)
                0: floor_set = 6'd1;
                1: floor_set = 6'd32;
                2: floor_set = 6'd63;
                3: floor_set = 6'd33;
                4: floor_set = 6'd0;
                default:
                    floor_set = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                            : 6'($urandom_range(1, 10));
            endcase
            write_min(floor_set);
            sent_bytes = 0;
            while (sent_bytes < BYTES_PER_PHASE)
                send_region(int'(floor_set));
        end

        settle();
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("x86_instruction_length_decoder: match");
        else
            $display("x86_instruction_length_decoder: mismatch");
        $finish;
    end

endmodule
